// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while reset is low.
`define TPD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("tilt detector check failed");

// Same, on the default clock and reset of the block.
`define TPD_ASSERT_DEF(lbl, prop) `TPD_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// ===== design/tpd_pkg.sv =====
// Shared types and constants of the tilt position detector.
package tpd_pkg;

  localparam int unsigned DEPTH_DEF       = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 14;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned AVG_BITS  = 14;
  localparam int unsigned THR_BITS  = 14;
  localparam int unsigned HYST_BITS = 12;
  localparam int unsigned HOLD_BITS = 8;
  localparam int unsigned ADDR_BITS = 4;
  localparam int unsigned DATA_BITS = 32;

  localparam logic [THR_BITS-1:0]  THR_POS_RST = 14'd1638;
  localparam logic [THR_BITS-1:0]  THR_NEG_RST = 14'h399A; // -1638
  localparam logic [HYST_BITS-1:0] HYST_RST    = 12'd42;
  localparam logic [HOLD_BITS-1:0] HOLD_RST    = 8'd0;
  localparam logic [HOLD_BITS-1:0] CNT_MAX     = 8'hFF;

  typedef enum logic [1:0] {
    POS_NONE  = 2'd0,
    POS_SIDE0 = 2'd1,
    POS_SIDE1 = 2'd2
  } pos_e;

  typedef enum logic [1:0] {
    REG_THR_POS = 2'd0,
    REG_THR_NEG = 2'd1,
    REG_HYST    = 2'd2,
    REG_HOLD    = 2'd3
  } reg_e;

  typedef struct packed {
    logic [THR_BITS-1:0]  thr_pos;
    logic [THR_BITS-1:0]  thr_neg;
    logic [HYST_BITS-1:0] hyst;
    logic [HOLD_BITS-1:0] hold;
  } cfg_t;

endpackage

// ===== design/tpd_front.sv =====
// Front end: sample ring memory, write index and old-sample fetch.
module tpd_front #(
  parameter int unsigned DEPTH       = tpd_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = tpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   push_o,
  input  logic                   push_ready_i,
  output logic [SAMPLE_BITS-1:0] push_sample_o,
  output logic [SAMPLE_BITS-1:0] push_old_o
);

  localparam int unsigned K = $clog2(DEPTH);

  logic [SAMPLE_BITS-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]       vld_q;
  logic [K-1:0]           idx_q;
  logic                   fv_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [SAMPLE_BITS-1:0] rd_q;
  logic                   rd_vld_q;
  logic                   acc;

  assign in_ready_o = !fv_q || push_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign push_o     = fv_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q          <= mem_q[idx_q];
      mem_q[idx_q]  <= sample_i;
      smp_q         <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      idx_q    <= '0;
      fv_q     <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      if (acc) begin
        rd_vld_q     <= vld_q[idx_q];
        vld_q[idx_q] <= 1'b1;
        idx_q        <= K'(idx_q + 1'b1);
        fv_q         <= 1'b1;
      end else if (push_ready_i) begin
        fv_q <= 1'b0;
      end
    end
  end

  assign push_sample_o = smp_q;
  assign push_old_o    = rd_vld_q ? rd_q : '0;

endmodule

// ===== design/tpd_fifo.sv =====
// Two-entry queue between front and back end.
module tpd_fifo #(
  parameter int unsigned WIDTH = 2 * tpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PW = $clog2(tpd_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0] buf_q [tpd_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wp_q;
  logic [PW-1:0]    rp_q;
  logic [PW:0]      cnt_q;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = cnt_q < (PW+1)'(tpd_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= PW'(wp_q + 1'b1);
      end
      if (do_pop) begin
        rp_q <= PW'(rp_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/tpd_back.sv =====
// Back end: running sum, average, hysteresis classification, hold counter and output register.
module tpd_back #(
  parameter int unsigned DEPTH       = tpd_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = tpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tpd_pkg::cfg_t                 cfg_i,
  input  logic                          pop_valid_i,
  output logic                          pop_o,
  input  logic [SAMPLE_BITS-1:0]        smp_i,
  input  logic [SAMPLE_BITS-1:0]        old_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tpd_pkg::AVG_BITS-1:0]  average_o,
  output logic [1:0]                    position_o,
  output logic                          changed_o
);

  localparam int unsigned K     = $clog2(DEPTH);
  localparam int unsigned SUM_W = SAMPLE_BITS + K;
  localparam int unsigned CMP_W = ((SAMPLE_BITS > tpd_pkg::THR_BITS) ?
                                   SAMPLE_BITS : tpd_pkg::THR_BITS) + 2;

  logic signed [SUM_W-1:0]       sum_q, sum_d;
  tpd_pkg::pos_e                 held_q, held_d;
  logic [tpd_pkg::HOLD_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic                          ov_q;
  logic [tpd_pkg::AVG_BITS-1:0]  avg_q;
  logic                          chg_q, chg_d;
  logic signed [SAMPLE_BITS-1:0] smp_s, old_s, avg;
  logic signed [CMP_W-1:0]       avg_x, thr_p, thr_n, hy_x, tp, tn;
  tpd_pkg::pos_e                 cls;
  logic                          take;

  assign pop_o = !ov_q || out_ready_i;
  assign take  = pop_o && pop_valid_i;

  always_comb begin
    smp_s = $signed(smp_i);
    old_s = $signed(old_i);
    sum_d = sum_q + SUM_W'(smp_s) - SUM_W'(old_s);
    avg   = $signed(sum_d[SUM_W-1:K]);
    avg_x = CMP_W'(avg);
    thr_p = CMP_W'($signed(cfg_i.thr_pos));
    thr_n = CMP_W'($signed(cfg_i.thr_neg));
    hy_x  = (held_q != tpd_pkg::POS_NONE) ? CMP_W'($signed({1'b0, cfg_i.hyst})) : '0;
    tp    = thr_p - hy_x;
    tn    = thr_n + hy_x;
    if (avg_x > tp) begin
      cls = tpd_pkg::POS_SIDE0;
    end else if (avg_x < tn) begin
      cls = tpd_pkg::POS_SIDE1;
    end else begin
      cls = tpd_pkg::POS_NONE;
    end
    cnt_inc = (cnt_q == tpd_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;
    held_d  = held_q;
    chg_d   = 1'b0;
    if (cls == held_q) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_inc;
      if (cnt_inc > cfg_i.hold) begin
        held_d = cls;
        chg_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      avg_q <= avg_x[tpd_pkg::AVG_BITS-1:0];
      chg_q <= chg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      held_q <= tpd_pkg::POS_NONE;
      cnt_q  <= tpd_pkg::CNT_MAX;
      ov_q   <= 1'b0;
    end else begin
      if (take) begin
        sum_q  <= sum_d;
        held_q <= held_d;
        cnt_q  <= cnt_d;
        ov_q   <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign average_o   = avg_q;
  assign position_o  = held_q;
  assign changed_o   = chg_q;

endmodule

// ===== design/tilt_position_detector.sv =====
// Top level of the tilt position detector: config registers and datapath wiring.
//
// One signed axis sample is taken per input beat (in_valid_i/in_ready_o) and
// one result beat (out_valid_o/out_ready_i) comes back for it, carrying the
// moving average of the last DEPTH samples, the held position and a changed
// flag. Results keep input order.
// Throughput is one beat per cycle while the receiver takes results. After the
// input accept the beat loads the front register (ring read), then moves into
// the two-entry queue, then loads the output register behind the running-sum
// and threshold logic, which raises result valid.
// When the receiver stalls, the result holds and input keeps flowing until
// the queue and the front register fill, then in_ready_o drops.
// Reset clears the ring (per-entry valid bits), the running sum, the held
// position (none) and sets the mismatch counter to its maximum; registers
// return to thresholds +1638/-1638, hysteresis 42, hold 0.
// Registers sit on the APB port at byte addresses 0, 4, 8, 12; write only
// while idle. pready is always high.
module tilt_position_detector #(
  parameter int unsigned DEPTH       = tpd_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = tpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tpd_pkg::AVG_BITS-1:0]    average_o,
  output logic [1:0]                      position_o,
  output logic                            changed_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tpd_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [tpd_pkg::DATA_BITS-1:0]   pwdata,
  output logic [tpd_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready
);

  tpd_pkg::cfg_t          cfg_q;
  tpd_pkg::reg_e          ridx;
  logic                   wr;
  logic                   push, push_ready, pop_valid, pop;
  logic [SAMPLE_BITS-1:0] push_smp, push_old, pop_smp, pop_old;

  assign pready = 1'b1;
  assign ridx   = tpd_pkg::reg_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr_pos <= tpd_pkg::THR_POS_RST;
      cfg_q.thr_neg <= tpd_pkg::THR_NEG_RST;
      cfg_q.hyst    <= tpd_pkg::HYST_RST;
      cfg_q.hold    <= tpd_pkg::HOLD_RST;
    end else if (wr) begin
      case (ridx)
        tpd_pkg::REG_THR_POS: cfg_q.thr_pos <= pwdata[tpd_pkg::THR_BITS-1:0];
        tpd_pkg::REG_THR_NEG: cfg_q.thr_neg <= pwdata[tpd_pkg::THR_BITS-1:0];
        tpd_pkg::REG_HYST:    cfg_q.hyst    <= pwdata[tpd_pkg::HYST_BITS-1:0];
        tpd_pkg::REG_HOLD:    cfg_q.hold    <= pwdata[tpd_pkg::HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      tpd_pkg::REG_THR_POS: prdata = tpd_pkg::DATA_BITS'(cfg_q.thr_pos);
      tpd_pkg::REG_THR_NEG: prdata = tpd_pkg::DATA_BITS'(cfg_q.thr_neg);
      tpd_pkg::REG_HYST:    prdata = tpd_pkg::DATA_BITS'(cfg_q.hyst);
      tpd_pkg::REG_HOLD:    prdata = tpd_pkg::DATA_BITS'(cfg_q.hold);
      default:              prdata = '0;
    endcase
  end

  tpd_front #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .push_sample_o (push_smp),
    .push_old_o    (push_old)
  );

  tpd_fifo #(
    .WIDTH (2 * SAMPLE_BITS)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  ({push_smp, push_old}),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   ({pop_smp, pop_old})
  );

  tpd_back #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .smp_i       (pop_smp),
    .old_i       (pop_old),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .average_o   (average_o),
    .position_o  (position_o),
    .changed_o   (changed_o)
  );

endmodule

// ===== design/tpd_checker.sv =====
// Port-level checker for the tilt position detector, with its bind.
`include "assert_macros.svh"

module tpd_checker #(
  parameter int unsigned SAMPLE_BITS = tpd_pkg::SAMPLE_BITS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [SAMPLE_BITS-1:0]         sample_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [tpd_pkg::AVG_BITS-1:0]   average_o,
  input logic [1:0]                     position_o,
  input logic                           changed_o
);

  logic [1:0] last_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q <= tpd_pkg::POS_NONE;
    end else if (out_valid_o && out_ready_i) begin
      last_pos_q <= position_o;
    end
  end

  // waiting input beat holds
  `TPD_ASSERT_DEF(a_in_hold, in_valid_i && !in_ready_o |=> in_valid_i && $stable(sample_i))

  // input only backs up behind a stalled result
  `TPD_ASSERT_DEF(a_backpressure, !in_ready_o |-> out_valid_o)

  // stalled result beat holds
  `TPD_ASSERT_DEF(a_out_hold, out_valid_o && !out_ready_i |=>
    out_valid_o && $stable(average_o) && $stable(position_o) && $stable(changed_o))

  // position moves only on a beat flagged changed
  `TPD_ASSERT_DEF(a_pos_keep, out_valid_o && !changed_o |-> position_o == last_pos_q)

  // a changed beat really moves the position
  `TPD_ASSERT_DEF(a_pos_move, out_valid_o && changed_o |-> position_o != last_pos_q)

endmodule

bind tilt_position_detector tpd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_tpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .sample_i    (sample_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .average_o   (average_o),
  .position_o  (position_o),
  .changed_o   (changed_o)
);
